FILE: src/tqtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold buffer package
// Beat types, action codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
package tqtb_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] kept_value;
    logic signed [31:0] threshold;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_RD,
    ST_CMP,
    ST_SWAP,
    ST_SWAP2,
    ST_E0,
    ST_E1,
    ST_E2,
    ST_QR,
    ST_QL
  } state_e;

endpackage

FILE: src/tqtb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tqtb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/top_q_threshold_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k threshold buffer
// Keeps the largest KEEP_COUNT values of a stream with an admission threshold.
// ----------------------------------------------------------------------------
// Usage: input beats carry an action and a value on a valid/stall channel.
// An insert below the threshold is dropped; otherwise it is written into the
// next slot downward. An insert that fills slot zero starts a quickselect over
// the buffer memory. The pace of each partition pass is set by the single read
// port of the buffer memory, and the passes shrink around the target rank.
// A query runs the same selection and then emits min(KEEP_COUNT, BUFFER_SIZE)
// beats, the final one flagged by last. A clear produces no beat.
// After reset the block runs a clearing pass that zeroes the buffer; input
// stall is held high until it ends.
// Input stall is high whenever the block is not idle. A stalled output beat
// holds, and query emission waits for it; the next input beat can be taken
// while the final query beat still waits.
// ----------------------------------------------------------------------------
module top_q_threshold_buffer_top
  import tqtb_pkg::*;
#(
  parameter int KEEP_COUNT  = 32,
  parameter int BUFFER_SIZE = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int AW   = $clog2(BUFFER_SIZE);
  localparam int WW   = $clog2(BUFFER_SIZE + 1);
  localparam int KEPT = (KEEP_COUNT < BUFFER_SIZE) ? KEEP_COUNT : BUFFER_SIZE;
  localparam int FREE = BUFFER_SIZE - KEPT;
  localparam logic [AW-1:0] Target  = AW'(FREE);
  localparam logic [AW-1:0] LastIdx = AW'(BUFFER_SIZE - 1);
  localparam logic [WW-1:0] WiReset = WW'(BUFFER_SIZE);
  localparam logic [WW-1:0] WiFree  = WW'(FREE);

  state_e state_q, state_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, dest_q, dest_d, k_q, k_d;
  logic signed [31:0] pv_q, pv_d, tmp_q, tmp_d, cur_q, cur_d, thr_q, thr_d;
  logic [WW-1:0] wi_q, wi_d, wn;
  logic qry_q, qry_d, ov_q, ov_d, adv;
  out_t out_q, out_d;

  logic we;
  logic [AW-1:0] waddr, raddr, dn;
  logic [31:0] wdata, rdata;
  logic signed [31:0] rd;

  assign rd = $signed(rdata);

  tqtb_ram #(.Width(32), .Depth(BUFFER_SIZE)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      k_q     <= '0;
      wi_q    <= WiReset;
      thr_q   <= -32'sd1;
      qry_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      wi_q    <= wi_d;
      thr_q   <= thr_d;
      qry_q   <= qry_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    i_q    <= i_d;
    dest_q <= dest_d;
    pv_q   <= pv_d;
    tmp_q  <= tmp_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d = state_q;
    lo_d = lo_q; hi_d = hi_q; i_d = i_q; dest_d = dest_q; k_d = k_q;
    pv_d = pv_q; tmp_d = tmp_q; cur_d = cur_q; thr_d = thr_q;
    wi_d = wi_q; qry_d = qry_q; out_d = out_q;
    ov_d = ov_q && out_stall_i;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    adv = 1'b0;
    wn = wi_q - 1'b1;
    dn = dest_q - 1'b1;
    unique case (state_q)
      ST_CLR: begin
        we = 1'b1; waddr = k_q;
        if (k_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            ACT_INSERT: begin
              if (in_data_i.value >= thr_q && wi_q != '0) begin
                wi_d = wn;
                we = 1'b1; waddr = wn[AW-1:0]; wdata = in_data_i.value;
                if (wn == '0) begin
                  qry_d = 1'b0; lo_d = '0; hi_d = LastIdx; state_d = ST_P0;
                end
              end
            end
            ACT_QUERY: begin
              qry_d = 1'b1; lo_d = '0; hi_d = LastIdx; state_d = ST_P0;
            end
            ACT_CLEAR: begin
              thr_d = -32'sd1; wi_d = WiReset;
            end
            default: ;
          endcase
        end
      end
      ST_P0: begin
        raddr = lo_q; state_d = ST_P1;
      end
      ST_P1: begin
        pv_d = rd; raddr = hi_q; state_d = ST_P2;
      end
      ST_P2: begin
        tmp_d = rd; we = 1'b1; waddr = hi_q; wdata = pv_q; state_d = ST_P3;
      end
      ST_P3: begin
        we = 1'b1; waddr = lo_q; wdata = tmp_q;
        i_d = hi_q - 1'b1; dest_d = hi_q;
        state_d = (hi_q == lo_q) ? ST_E0 : ST_RD;
      end
      ST_RD: begin
        raddr = i_q; state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rd > pv_q) begin
          cur_d = rd; dest_d = dn;
          if (dn == i_q) begin
            adv = 1'b1;
          end else begin
            raddr = dn; state_d = ST_SWAP;
          end
        end else begin
          adv = 1'b1;
        end
      end
      ST_SWAP: begin
        tmp_d = rd; we = 1'b1; waddr = dest_q; wdata = cur_q; state_d = ST_SWAP2;
      end
      ST_SWAP2: begin
        we = 1'b1; waddr = i_q; wdata = tmp_q; adv = 1'b1;
      end
      ST_E0: begin
        raddr = dest_q; state_d = ST_E1;
      end
      ST_E1: begin
        tmp_d = rd; we = 1'b1; waddr = dest_q; wdata = pv_q; state_d = ST_E2;
      end
      ST_E2: begin
        we = 1'b1; waddr = hi_q; wdata = tmp_q;
        if (dest_q == Target) begin
          thr_d = pv_q; wi_d = WiFree; k_d = Target;
          state_d = qry_q ? ST_QR : ST_IDLE;
        end else if (dest_q > Target) begin
          hi_d = dn; state_d = ST_P0;
        end else begin
          lo_d = dest_q + 1'b1; state_d = ST_P0;
        end
      end
      ST_QR: begin
        if (!ov_q || !out_stall_i) begin
          raddr = k_q; state_d = ST_QL;
        end
      end
      ST_QL: begin
        ov_d = 1'b1;
        out_d.kept_value = rd;
        out_d.threshold  = thr_q;
        out_d.last       = (k_q == LastIdx);
        if (k_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1; state_d = ST_QR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (adv) begin
      if (i_q == lo_q) begin
        state_d = ST_E0;
      end else begin
        i_d = i_q - 1'b1; state_d = ST_RD;
      end
    end
  end

`ifndef SYNTHESIS
  a_wi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q <= WiReset) else $error("write index out of range");
  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == ST_QL)) else $error("beat without load");
  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.action == ACT_QUERY) |=> state_q == ST_P0)
    else $error("query did not start selection");
  a_no_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QL) |-> $past(!ov_q || !out_stall_i)) else $error("beat overrun");
`endif

endmodule

FILE: tb/top_q_threshold_buffer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k threshold buffer testbench
// Drives insert, query and clear beats with random idling on both channels.
// A behavioral copy of the buffer, its threshold and its quickselect predicts
// query beats of unfixed rows, each checked field by field against the block.
// ----------------------------------------------------------------------------
module top_q_threshold_buffer_top_tb;
  import tqtb_pkg::*;

  localparam int KEEP_COUNT  = 32;
  localparam int BUFFER_SIZE = 64;
  localparam int KEPT_NUM    = (KEEP_COUNT < BUFFER_SIZE) ? KEEP_COUNT : BUFFER_SIZE;
  localparam int FREE_LIMIT  = BUFFER_SIZE - KEPT_NUM;
  localparam int RANDOM_ITEMS = 290;
  localparam int QUIET_ITEMS  = 40;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] value;
    bit                 fixed;
    logic signed [31:0] kept;
    logic signed [31:0] thr;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  logic signed [31:0] slot_mem [BUFFER_SIZE];
  int unsigned        next_slot;
  logic signed [31:0] admit_thr;

  out_t pending_beats[$];
  row_t stim_table[$];
  int   mismatch_count;
  bit   quiet;
  logic signed [31:0] ramp_value;

  top_q_threshold_buffer_top #(
    .KEEP_COUNT (KEEP_COUNT),
    .BUFFER_SIZE(BUFFER_SIZE)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("top_q_threshold_buffer_top_tb: done, errors");
    $finish;
  end

  function automatic void swap_slots(int a, int b);
    logic signed [31:0] t;
    t           = slot_mem[a];
    slot_mem[a] = slot_mem[b];
    slot_mem[b] = t;
  endfunction

  function automatic int partition_left(int lo, int hi);
    logic signed [31:0] pv;
    int dest;
    pv   = slot_mem[lo];
    dest = hi;
    swap_slots(lo, hi);
    for (int i = hi - 1; i >= lo; i--) begin
      if (slot_mem[i] > pv) begin
        dest--;
        swap_slots(i, dest);
      end
    end
    swap_slots(hi, dest);
    return dest;
  endfunction

  function automatic void select_threshold();
    int lo;
    int hi;
    int p;
    lo = 0;
    hi = BUFFER_SIZE - 1;
    while (lo <= hi) begin
      p = partition_left(lo, hi);
      if (p == FREE_LIMIT) begin
        admit_thr = slot_mem[p];
        break;
      end else if (p > FREE_LIMIT) begin
        hi = p - 1;
      end else begin
        lo = p + 1;
      end
    end
    next_slot = FREE_LIMIT;
  endfunction

  // Updates the buffer copy for one accepted beat and queues the query beats.
  function automatic void apply_beat(row_t r);
    out_t b;
    case (r.action)
      ACT_INSERT: begin
        if (r.value >= admit_thr && next_slot != 0 && next_slot <= BUFFER_SIZE) begin
          next_slot--;
          slot_mem[next_slot] = r.value;
          if (next_slot == 0) select_threshold();
        end
      end
      ACT_QUERY: begin
        select_threshold();
        for (int k = 0; k < KEPT_NUM; k++) begin
          b.kept_value = r.fixed ? r.kept : slot_mem[FREE_LIMIT + k];
          b.threshold  = r.fixed ? r.thr : admit_thr;
          b.last       = (k == KEPT_NUM - 1);
          pending_beats.push_back(b);
        end
      end
      ACT_CLEAR: begin
        admit_thr = -1;
        next_slot = BUFFER_SIZE;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned m;
    m = $urandom_range(99);
    if (m < 35) return $urandom;
    if (m < 65) return $signed($urandom_range(100)) - 50;
    if (m < 80) begin
      case ($urandom_range(3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return -1;
        default: return 0;
      endcase
    end
    ramp_value = ramp_value + $signed($urandom_range(3));
    return ramp_value;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int unsigned m;
    m = $urandom_range(99);
    r.fixed = 1'b0;
    r.kept  = '0;
    r.thr   = '0;
    r.value = pick_value();
    if (m < 86) r.action = ACT_INSERT;
    else if (m < 93) r.action = ACT_QUERY;
    else if (m < 97) r.action = ACT_CLEAR;
    else r.action = ACT_UNUSED;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] a, logic signed [31:0] v, bit f,
                                  logic signed [31:0] k, logic signed [31:0] t);
    row_t r;
    r.action = a;
    r.value  = v;
    r.fixed  = f;
    r.kept   = k;
    r.thr    = t;
    stim_table.push_back(r);
  endfunction

  task automatic send_beat(row_t r);
    int unsigned gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      in_data_i  <= in_t'({2'($urandom), 32'($urandom)});
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_data_i.action <= r.action;
    in_data_i.value  <= r.value;
    do @(posedge clk_i); while (in_stall_o);
    apply_beat(r);
  endtask

  always @(posedge clk_i) begin
    out_t got;
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_beats.pop_front();
        if (got.kept_value !== want.kept_value) begin
          $display("%0t kept_value: expected %0d, actual %0d", $time,
                   want.kept_value, got.kept_value);
          mismatch_count++;
        end
        if (got.threshold !== want.threshold) begin
          $display("%0t threshold: expected %0d, actual %0d", $time,
                   want.threshold, got.threshold);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t last: expected %0b, actual %0b", $time, want.last, got.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet || $urandom_range(1) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  initial begin
    row_t r;
    mismatch_count = 0;
    quiet          = 1'b0;
    ramp_value     = -20;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    for (int i = 0; i < BUFFER_SIZE; i++) slot_mem[i] = '0;
    next_slot = BUFFER_SIZE;
    admit_thr = -1;

    add_row(ACT_QUERY,  0,            1'b1, 0, 0);
    add_row(ACT_INSERT, 32'sh7fffffff, 1'b0, 0, 0);
    add_row(ACT_INSERT, 32'sh80000000, 1'b0, 0, 0);
    add_row(ACT_INSERT, -1,           1'b0, 0, 0);
    add_row(ACT_INSERT, 0,            1'b0, 0, 0);
    add_row(ACT_INSERT, -2,           1'b0, 0, 0);
    add_row(ACT_UNUSED, -1,           1'b0, 0, 0);
    add_row(ACT_QUERY,  32'sh55555555, 1'b0, 0, 0);
    add_row(ACT_CLEAR,  32'sh2aaaaaaa, 1'b0, 0, 0);
    add_row(ACT_INSERT, 32'sh80000000, 1'b0, 0, 0);
    add_row(ACT_INSERT, 32'sh7ffffffe, 1'b0, 0, 0);
    add_row(ACT_INSERT, 5,            1'b0, 0, 0);
    add_row(ACT_QUERY,  0,            1'b0, 0, 0);
    add_row(ACT_INSERT, -1,           1'b0, 0, 0);
    add_row(ACT_INSERT, 32'sh7fffffff, 1'b0, 0, 0);
    add_row(ACT_CLEAR,  0,            1'b0, 0, 0);
    add_row(ACT_QUERY,  0,            1'b0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) send_beat(stim_table[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        wait (pending_beats.size() == 0);
        @(posedge clk_i);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      r = random_row();
      send_beat(r);
    end
    in_valid_i <= 1'b0;

    wait (pending_beats.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("top_q_threshold_buffer_top_tb: done, clean");
    end else begin
      $display("top_q_threshold_buffer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
